// ===== rtl/anxb_pkg.sv =====
// Shared types and constants for the Annex B start-code NAL scanner.
// No dependencies; used by the scan core, the top level and the testbench.
package anxb_pkg;

  typedef enum logic [1:0] {
    CLS_SPS   = 2'd0,
    CLS_PPS   = 2'd1,
    CLS_APS   = 2'd2,
    CLS_OTHER = 2'd3
  } anxb_class_t;

  localparam logic MODE_H264 = 1'b0;
  localparam logic MODE_HEVC = 1'b1;

  localparam logic [5:0] H264_TYPE_SPS = 6'h07;
  localparam logic [5:0] HEVC_TYPE_SPS = 6'h21;
  localparam logic [5:0] HEVC_TYPE_PPS = 6'h22;
  localparam logic [5:0] HEVC_TYPE_APS = 6'd20;

  localparam logic [7:0]  MAX_UNITS = 8'd32;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  typedef struct packed {
    anxb_class_t nal_class;
    logic [5:0]  nal_type;
    logic [15:0] nal_length;
    logic        length_saturated;
    logic [7:0]  class_index;
    logic        is_final;
  } anxb_unit_t;

endpackage

// ===== rtl/anxb_if.sv =====
// Valid/ready channel interfaces: stream bytes in, closed NAL unit reports out.
// Depends on nothing; field widths follow anxb_pkg::anxb_unit_t.
interface anxb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface anxb_unit_if;
  logic        valid;
  logic        ready;
  logic [1:0]  nal_class;
  logic [5:0]  nal_type;
  logic [15:0] nal_length;
  logic        length_saturated;
  logic [7:0]  class_index;
  logic        is_final;

  modport source (output valid, output nal_class, output nal_type, output nal_length,
                  output length_saturated, output class_index, output is_final,
                  input ready);
  modport sink (input valid, input nal_class, input nal_type, input nal_length,
                input length_saturated, input class_index, input is_final,
                output ready);
endinterface

// ===== rtl/anxb_scan_core.sv =====
// Per-beat scanner state: start-code detection, header decode, length and class counts.
// Depends on anxb_pkg. State advances on step; result is combinational for that beat.
module anxb_scan_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                codec_mode,
  input  logic                step,
  input  logic [7:0]          stream_byte,
  input  logic                end_of_stream,
  output logic                res_valid,
  output anxb_pkg::anxb_unit_t res
);

  logic [1:0]            zero_run, zero_run_next;
  logic                  in_unit, in_unit_next;
  logic                  header_pending, header_pending_next;
  logic [5:0]            current_type, current_type_next;
  anxb_pkg::anxb_class_t current_class, current_class_next;
  logic [16:0]           byte_count, byte_count_next;
  logic [7:0]            class_counts [0:2];
  logic [7:0]            class_counts_next [0:2];
  logic [7:0]            unit_total, unit_total_next;
  logic                  unit_tracked, unit_tracked_next;

  logic [5:0]            dec_type;
  anxb_pkg::anxb_class_t dec_class;
  logic                  emit_req;
  logic                  clear_req;
  anxb_pkg::anxb_class_t emit_class;
  logic [5:0]            emit_type;
  logic [16:0]           emit_len;
  logic [7:0]            emit_idx;

  always_comb begin
    if (codec_mode == anxb_pkg::MODE_HEVC) begin
      dec_type = stream_byte[6:1];
      if (dec_type == anxb_pkg::HEVC_TYPE_SPS) begin
        dec_class = anxb_pkg::CLS_SPS;
      end else if (dec_type == anxb_pkg::HEVC_TYPE_PPS) begin
        dec_class = anxb_pkg::CLS_PPS;
      end else if (dec_type == anxb_pkg::HEVC_TYPE_APS) begin
        dec_class = anxb_pkg::CLS_APS;
      end else begin
        dec_class = anxb_pkg::CLS_OTHER;
      end
    end else begin
      dec_type  = {1'b0, stream_byte[4:0]};
      dec_class = (dec_type == anxb_pkg::H264_TYPE_SPS) ? anxb_pkg::CLS_SPS
                                                        : anxb_pkg::CLS_PPS;
    end
  end

  always_comb begin
    zero_run_next       = zero_run;
    in_unit_next        = in_unit;
    header_pending_next = header_pending;
    current_type_next   = current_type;
    current_class_next  = current_class;
    byte_count_next     = byte_count;
    class_counts_next   = class_counts;
    unit_total_next     = unit_total;
    unit_tracked_next   = unit_tracked;
    emit_req            = 1'b0;
    clear_req           = 1'b0;
    emit_class          = current_class;
    emit_type           = current_type;
    emit_len            = '0;
    emit_idx            = '0;

    if (header_pending) begin
      current_type_next   = dec_type;
      current_class_next  = dec_class;
      header_pending_next = 1'b0;
      byte_count_next     = 17'd1;
      zero_run_next       = 2'd0;
      emit_class          = dec_class;
      emit_type           = dec_type;
      emit_len            = 17'd1;
      emit_req            = end_of_stream;
      clear_req           = end_of_stream;
    end else if (zero_run == 2'd2 && stream_byte == 8'h01) begin
      // start code complete: close the open unit, open a new one
      emit_req          = in_unit;
      emit_len          = (byte_count >= 17'd2) ? byte_count - 17'd2 : '0;
      unit_tracked_next = unit_total < anxb_pkg::MAX_UNITS;
      if (unit_total != 8'hFF) begin
        unit_total_next = unit_total + 8'd1;
      end
      in_unit_next        = 1'b1;
      header_pending_next = 1'b1;
      zero_run_next       = 2'd0;
      byte_count_next     = '0;
      clear_req           = end_of_stream;
    end else begin
      if (stream_byte == 8'h00) begin
        if (zero_run != 2'd2) begin
          zero_run_next = zero_run + 2'd1;
        end
      end else begin
        zero_run_next = 2'd0;
      end
      if (in_unit && byte_count != anxb_pkg::COUNT_MAX) begin
        byte_count_next = byte_count + 17'd1;
      end
      emit_len  = byte_count_next;
      emit_req  = end_of_stream && in_unit;
      clear_req = end_of_stream;
    end

    res_valid = emit_req && unit_tracked;
    if (emit_class != anxb_pkg::CLS_OTHER) begin
      emit_idx = class_counts[emit_class];
      if (res_valid && emit_idx != 8'hFF) begin
        class_counts_next[emit_class] = emit_idx + 8'd1;
      end
    end

    res.nal_class        = emit_class;
    res.nal_type         = emit_type;
    res.nal_length       = emit_len[16] ? 16'hFFFF : emit_len[15:0];
    res.length_saturated = emit_len[16];
    res.class_index      = emit_idx;
    res.is_final         = end_of_stream;

    if (clear_req) begin
      zero_run_next        = 2'd0;
      in_unit_next         = 1'b0;
      header_pending_next  = 1'b0;
      current_type_next    = '0;
      current_class_next   = anxb_pkg::CLS_SPS;
      byte_count_next      = '0;
      class_counts_next[0] = '0;
      class_counts_next[1] = '0;
      class_counts_next[2] = '0;
      unit_total_next      = '0;
      unit_tracked_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run        <= 2'd0;
      in_unit         <= 1'b0;
      header_pending  <= 1'b0;
      current_type    <= '0;
      current_class   <= anxb_pkg::CLS_SPS;
      byte_count      <= '0;
      class_counts[0] <= '0;
      class_counts[1] <= '0;
      class_counts[2] <= '0;
      unit_total      <= '0;
      unit_tracked    <= 1'b0;
    end else if (step) begin
      zero_run       <= zero_run_next;
      in_unit        <= in_unit_next;
      header_pending <= header_pending_next;
      current_type   <= current_type_next;
      current_class  <= current_class_next;
      byte_count     <= byte_count_next;
      class_counts   <= class_counts_next;
      unit_total     <= unit_total_next;
      unit_tracked   <= unit_tracked_next;
    end
  end

endmodule

// ===== rtl/annexb_start_code_nal_scanner.sv =====
// Annex B start-code NAL scanner, top level: input beat register, scan core, result register.
// A result passes from the input beat register through the scan core into the result register.
// Throughput: one byte per cycle unless a result waits; then only an empty s1 takes a byte.
// Reset (rst, synchronous): clears pipeline valids, codec_mode (H.264) and all scan state.
// Depends on anxb_pkg, anxb_if.sv and anxb_scan_core.
module annexb_start_code_nal_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  anxb_byte_if.sink   bytes,
  anxb_unit_if.source units
);

  logic                 codec_mode;
  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_eos;
  logic                 out_free;
  logic                 s1_go;
  logic                 res_valid;
  anxb_pkg::anxb_unit_t res;
  logic                 out_valid;
  anxb_pkg::anxb_unit_t out_unit;

  assign out_free    = !out_valid || units.ready;
  assign s1_go       = s1_valid && out_free;
  assign bytes.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode <= anxb_pkg::MODE_H264;
    end else if (cfg_wr_en) begin
      codec_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.stream_byte;
      s1_eos  <= bytes.end_of_stream;
    end
  end

  anxb_scan_core u_core (
    .clk           (clk),
    .rst           (rst),
    .codec_mode    (codec_mode),
    .step          (s1_go),
    .stream_byte   (s1_byte),
    .end_of_stream (s1_eos),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res_valid) begin
      out_valid <= 1'b1;
    end else if (units.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && res_valid) begin
      out_unit <= res;
    end
  end

  assign units.valid            = out_valid;
  assign units.nal_class        = out_unit.nal_class;
  assign units.nal_type         = out_unit.nal_type;
  assign units.nal_length       = out_unit.nal_length;
  assign units.length_saturated = out_unit.length_saturated;
  assign units.class_index      = out_unit.class_index;
  assign units.is_final         = out_unit.is_final;

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result beat without a byte in the input register");

  a_other_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_unit.nal_class == anxb_pkg::CLS_OTHER |-> out_unit.class_index == 8'd0)
    else $error("unclassified unit carries a class index");

  a_sat_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_unit.length_saturated |-> out_unit.nal_length == 16'hFFFF)
    else $error("saturated length not at maximum");

  a_h264_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && codec_mode == anxb_pkg::MODE_H264
      |-> out_unit.nal_class == anxb_pkg::CLS_SPS || out_unit.nal_class == anxb_pkg::CLS_PPS)
    else $error("H.264 unit reported with HEVC-only class");

endmodule

// ===== tb/sv/annexb_start_code_nal_scanner_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for annexb_start_code_nal_scanner: a directed byte table, two
// maximum-length units, then random streams checked against an in-bench scan predictor.
// Depends on anxb_pkg, anxb_if.sv and the scanner RTL.
module annexb_start_code_nal_scanner_tb;
  import anxb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RAND_ITEMS    = 500;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_FILL     = 65534;
  localparam int unsigned BURST_UNITS   = 24;

  localparam anxb_unit_t NO_UNIT = '{CLS_SPS, 6'd0, 16'd0, 1'b0, 8'd0, 1'b0};

  typedef struct {
    logic       set_mode;
    logic [7:0] data;
    logic       eos;
    logic       typed;
    anxb_unit_t unit;
  } dir_row_t;

  logic clk         = 1'b0;
  logic rst         = 1'b1;
  logic cfg_wr_en   = 1'b0;
  logic cfg_wr_data = 1'b0;

  anxb_byte_if bytes_if();
  anxb_unit_if units_if();

  annexb_start_code_nal_scanner u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .bytes       (bytes_if),
    .units       (units_if)
  );

  always #5 clk = ~clk;

  // scan predictor state
  logic        mode_q;
  logic [1:0]  zrun;
  logic        open_unit;
  logic        hdr_next;
  logic [5:0]  cur_type;
  anxb_class_t cur_cls;
  logic [16:0] unit_bytes;
  logic [7:0]  cls_cnt [3];
  logic [7:0]  units_seen;
  logic        unit_kept;

  anxb_unit_t  pending_units [$];
  logic [7:0]  stream_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          steady;
  bit          long_hold_req;

  dir_row_t dir_rows [29] = '{
    '{1'b0, 8'hAB, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h67, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h01, 1'b0, 1'b1, '{CLS_SPS, 6'd7, 16'd3, 1'b0, 8'd0, 1'b0}},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h01, 1'b1, 1'b1, '{CLS_PPS, 6'd0, 16'd3, 1'b0, 8'd0, 1'b1}},
    '{1'b1, {7'd0, MODE_HEVC}, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h42, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h28, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h00, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'h01, 1'b0, 1'b0, NO_UNIT},
    '{1'b0, 8'hD1, 1'b1, 1'b0, NO_UNIT}
  };

  task automatic clear_scan();
    zrun       = 2'd0;
    open_unit  = 1'b0;
    hdr_next   = 1'b0;
    cur_type   = 6'd0;
    cur_cls    = CLS_SPS;
    unit_bytes = 17'd0;
    cls_cnt[0] = 8'd0;
    cls_cnt[1] = 8'd0;
    cls_cnt[2] = 8'd0;
    units_seen = 8'd0;
    unit_kept  = 1'b0;
  endtask

  task automatic decode_header(input logic [7:0] b);
    if (mode_q == MODE_HEVC) begin
      cur_type = b[6:1];
      if (cur_type == HEVC_TYPE_SPS) cur_cls = CLS_SPS;
      else if (cur_type == HEVC_TYPE_PPS) cur_cls = CLS_PPS;
      else if (cur_type == HEVC_TYPE_APS) cur_cls = CLS_APS;
      else cur_cls = CLS_OTHER;
    end else begin
      cur_type = {1'b0, b[4:0]};
      cur_cls  = (cur_type == H264_TYPE_SPS) ? CLS_SPS : CLS_PPS;
    end
  endtask

  task automatic close_unit(input int unsigned len, input logic fin);
    anxb_unit_t u;
    if (unit_kept) begin
      u.nal_class        = cur_cls;
      u.nal_type         = cur_type;
      u.nal_length       = (len > 65535) ? 16'hFFFF : 16'(len);
      u.length_saturated = (len > 65535);
      u.class_index      = 8'd0;
      if (cur_cls != CLS_OTHER) begin
        u.class_index = cls_cnt[cur_cls];
        if (cls_cnt[cur_cls] != 8'hFF) cls_cnt[cur_cls]++;
      end
      u.is_final = fin;
      pending_units.push_back(u);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eos);
    if (hdr_next) begin
      decode_header(b);
      hdr_next   = 1'b0;
      unit_bytes = 17'd1;
      zrun       = 2'd0;
      if (eos) begin
        close_unit(1, 1'b1);
        clear_scan();
      end
    end else if (zrun == 2'd2 && b == 8'h01) begin
      if (open_unit) close_unit((unit_bytes >= 2) ? unit_bytes - 2 : 0, eos);
      unit_kept = (units_seen < MAX_UNITS);
      if (units_seen != 8'hFF) units_seen++;
      open_unit  = 1'b1;
      hdr_next   = 1'b1;
      zrun       = 2'd0;
      unit_bytes = 17'd0;
      if (eos) clear_scan();
    end else begin
      if (b == 8'h00) begin
        if (zrun != 2'd2) zrun++;
      end else begin
        zrun = 2'd0;
      end
      if (open_unit && unit_bytes != COUNT_MAX) unit_bytes++;
      if (eos) begin
        if (open_unit) close_unit(unit_bytes, 1'b1);
        clear_scan();
      end
    end
  endtask

  function automatic int stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (steady) return 0;
    if ($urandom_range(0, 99) < 55) return 0;
    return stall_len();
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h00;
      3:       return 8'h01;
      4:       return 8'h03;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] header_byte();
    logic [7:0] r;
    r = 8'($urandom);
    if (mode_q == MODE_HEVC) begin
      case ($urandom_range(0, 4))
        0:       return {r[7], HEVC_TYPE_SPS, r[0]};
        1:       return {r[7], HEVC_TYPE_PPS, r[0]};
        2:       return {r[7], HEVC_TYPE_APS, r[0]};
        default: return r;
      endcase
    end
    if ($urandom_range(0, 3) == 0) return {r[7:5], H264_TYPE_SPS[4:0]};
    return r;
  endfunction

  // valid stays high after the beat until a later gap or wait_idle lowers it
  task automatic send_byte(input logic [7:0] b, input logic eos, output bit made);
    int gap;
    int n0;
    gap = pick_gap();
    if (gap > 0) begin
      bytes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_if.valid         <= 1'b1;
    bytes_if.stream_byte   <= b;
    bytes_if.end_of_stream <= eos;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    n0 = pending_units.size();
    scan_byte(b, eos);
    made = (pending_units.size() > n0);
  endtask

  task automatic wait_idle();
    bytes_if.valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_q = m;
  endtask

  task automatic build_stream();
    int unsigned n_units;
    stream_q.delete();
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 30)) stream_q.push_back(payload_byte());
    end else begin
      repeat ($urandom_range(0, 3)) stream_q.push_back(8'($urandom));
      n_units = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 6);
      repeat (n_units) begin
        if ($urandom_range(0, 3) == 0) stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        if ($urandom_range(0, 11) != 0) stream_q.push_back(8'h01);
        stream_q.push_back(header_byte());
        repeat ($urandom_range(0, 10)) stream_q.push_back(payload_byte());
      end
      case ($urandom_range(0, 2))
        1: begin
          stream_q.push_back(8'h00);
          stream_q.push_back(8'h00);
          stream_q.push_back(8'h01);
        end
        2: stream_q.push_back(payload_byte());
        default: ;
      endcase
    end
  endtask

  // short back-to-back units, one report per four beats
  task automatic build_burst();
    stream_q.delete();
    repeat (BURST_UNITS) begin
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h01);
      stream_q.push_back(header_byte());
    end
    stream_q.push_back(payload_byte());
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    anxb_unit_t want;
    if (!rst && units_if.valid && units_if.ready) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected unit report: expected none, got class=%0d type=%0d len=%0d",
                 $time, units_if.nal_class, units_if.nal_type, units_if.nal_length);
        errors++;
      end else begin
        want = pending_units.pop_front();
        check_field("nal_class", 16'(want.nal_class), 16'(units_if.nal_class));
        check_field("nal_type", 16'(want.nal_type), 16'(units_if.nal_type));
        check_field("nal_length", want.nal_length, units_if.nal_length);
        check_field("length_saturated", 16'(want.length_saturated),
                    16'(units_if.length_saturated));
        check_field("class_index", 16'(want.class_index), 16'(units_if.class_index));
        check_field("is_final", 16'(want.is_final), 16'(units_if.is_final));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("annexb_start_code_nal_scanner_tb failed");
      $finish;
    end
  end

  // result sink: random ready, plus one long hold on request
  initial begin
    int run_left;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        units_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
        run_left      = 0;
      end else if (steady) begin
        units_if.ready <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        units_if.ready <= 1'b0;
        run_left = stall_len() - 1;
      end else begin
        units_if.ready <= 1'b1;
        run_left = $urandom_range(0, 15);
      end
    end
  end

  initial begin
    dir_row_t    row;
    bit          made;
    bit          paused;
    int unsigned sent;
    int unsigned stream_no;

    bytes_if.valid         = 1'b0;
    bytes_if.stream_byte   = 8'h00;
    bytes_if.end_of_stream = 1'b0;
    units_if.ready         = 1'b0;
    steady                 = 1'b0;
    long_hold_req          = 1'b0;
    mode_q                 = MODE_H264;
    clear_scan();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.set_mode) begin
        write_mode(row.data[0]);
      end else begin
        send_byte(row.data, row.eos, made);
        if (row.typed) begin
          if (made) void'(pending_units.pop_back());
          pending_units.push_back(row.unit);
        end
      end
    end

    // lengths 65535 (closed by start code) and 65536 (saturated, closed by end of stream)
    wait_idle();
    steady = 1'b1;
    for (int k = 0; k < 2; k++) begin
      send_byte(8'h00, 1'b0, made);
      send_byte(8'h00, 1'b0, made);
      send_byte(8'h01, 1'b0, made);
      send_byte(header_byte(), 1'b0, made);
      repeat (LONG_FILL) send_byte(8'hAA, 1'b0, made);
    end
    send_byte(8'hAA, 1'b1, made);
    wait_idle();
    steady = 1'b0;

    sent      = 0;
    stream_no = 0;
    paused    = 1'b0;
    while (sent < RAND_ITEMS) begin
      if (stream_no == 0) write_mode(MODE_H264);
      else if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 4) == 0);
      if (stream_no == 2) begin
        long_hold_req = 1'b1;
        build_burst();
      end else begin
        build_stream();
      end
      foreach (stream_q[i]) begin
        if (!paused && sent == RAND_ITEMS / 2) begin
          paused = 1'b1;
          wait_idle();
        end
        send_byte(stream_q[i], (i == stream_q.size() - 1), made);
        sent++;
      end
      stream_no++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("annexb_start_code_nal_scanner_tb passed");
    end else begin
      $display("annexb_start_code_nal_scanner_tb failed");
    end
    $finish;
  end

endmodule
